### rtl/scaled_glyph_framebuffer_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer writer assertion macros
// Concurrent assertion helpers shared by the framebuffer writer RTL.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH
`define SCALED_GLYPH_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH

`ifndef SYNTH
`define SGFW_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgfw assertion failed");
`define SGFW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgfw assertion failed");
`else
`define SGFW_ASSERT_IMPL(name, ante, cons)
`define SGFW_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/sgfw_pkg.sv
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer writer package
// Operation codes, controller states, command and status bundles, font table.
// ----------------------------------------------------------------------------
`default_nettype none

package sgfw_pkg;

	localparam logic [2:0] FN_GLYPH  = 3'd0;
	localparam logic [2:0] FN_CURSOR = 3'd1;
	localparam logic [2:0] FN_CLEAR  = 3'd2;
	localparam logic [2:0] FN_PIXEL  = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_COUNT = 96;
	localparam int FIRST_CODE  = 32;
	localparam int SCALE_W     = 4;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_G_RD,
		ST_G_LOAD,
		ST_G_PIX,
		ST_G_WR,
		ST_G_WR_LAST,
		ST_P_RD,
		ST_P_WR,
		ST_R_RD,
		ST_R_CAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mem_rd;
		logic read_rd;
		logic byte_load;
		logic pix_step;
		logic glyph_wr;
		logic pixel_wr;
		logic read_cap;
		logic clr_step;
		logic cur_adv;
		logic cur_home;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic byte_end;
		logic y_last;
		logic x_last;
		logic clr_last;
		logic out_free;
	} dp_status_t;

	// Each entry holds the five glyph columns, leftmost column in the top byte.
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	function automatic logic [7:0] glyph_column(input logic [6:0] g, input logic [2:0] gx);
		logic [39:0] row;
		row = GLYPH_ROM[g];
		return row[(GLYPH_COLS - 1 - int'(gx)) * 8 +: 8];
	endfunction

endpackage

`default_nettype wire

### rtl/sgfw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 504
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/sgfw_ctrl.sv
// ----------------------------------------------------------------------------
// Framebuffer writer controller
// Sequences the clear sweep, glyph raster, pixel write, byte read and result.
// ----------------------------------------------------------------------------
`default_nettype none

module sgfw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             func,
	input  sgfw_pkg::dp_status_t   status,
	output sgfw_pkg::ctrl_cmd_t    cmd
);

	import sgfw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (func)
						FN_GLYPH:  state_d = ST_G_RD;
						FN_CURSOR: state_d = ST_DONE;
						FN_CLEAR:  state_d = ST_CLEAR;
						FN_PIXEL:  state_d = ST_P_RD;
						FN_READ:   state_d = ST_R_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					cmd.cur_home = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_G_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_G_LOAD;
			end
			ST_G_LOAD: begin
				cmd.byte_load = 1'b1;
				state_d       = ST_G_PIX;
			end
			ST_G_PIX: begin
				cmd.pix_step = 1'b1;
				if (status.byte_end) begin
					state_d = (status.y_last && status.x_last) ? ST_G_WR_LAST : ST_G_WR;
				end
			end
			ST_G_WR: begin
				cmd.glyph_wr = 1'b1;
				state_d      = ST_G_RD;
			end
			ST_G_WR_LAST: begin
				cmd.glyph_wr = 1'b1;
				cmd.cur_adv  = 1'b1;
				state_d      = ST_DONE;
			end
			ST_P_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_P_WR;
			end
			ST_P_WR: begin
				cmd.pixel_wr = 1'b1;
				state_d      = ST_DONE;
			end
			ST_R_RD: begin
				cmd.read_rd = 1'b1;
				state_d     = ST_R_CAP;
			end
			ST_R_CAP: begin
				cmd.read_cap = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/sgfw_dp.sv
// ----------------------------------------------------------------------------
// Framebuffer writer datapath
// Frame store, raster counters, cursor registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgfw_dp #(
	parameter int SCREEN_WIDTH  = 84,
	parameter int SCREEN_HEIGHT = 48,
	parameter int MAX_SCALE     = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgfw_pkg::ctrl_cmd_t  cmd,
	output sgfw_pkg::dp_status_t status,
	input  logic [2:0]           func,
	input  logic [6:0]           char_code,
	input  logic [2:0]           glyph_scale,
	input  logic [6:0]           pos_x,
	input  logic [5:0]           pos_y,
	input  logic                 pixel_value,
	input  logic [8:0]           byte_index,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [7:0]           read_data,
	output logic [6:0]           cursor_col,
	output logic [5:0]           cursor_row
);

	import sgfw_pkg::*;

	localparam int STORE_BYTES = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int IDX_W       = $clog2(32 * SCREEN_WIDTH + 256);

	logic [7:0]         px_q;
	logic [6:0]         py_q;
	logic               val_q;
	logic [8:0]         bidx_q;
	logic [6:0]         g_q;
	logic [SCALE_W-1:0] s_q;
	logic [2:0]         cx_q;
	logic [2:0]         gx_q;
	logic [2:0]         cy_q;
	logic [2:0]         gy_q;
	logic [7:0]         byte_q;
	logic [IDX_W-1:0]   addr_q;
	logic [AW-1:0]      clr_q;
	logic [6:0]         col_q;
	logic [5:0]         row_q;
	logic [7:0]         rdata_q;
	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic [6:0]         out_col_q;
	logic [5:0]         out_row_q;

	logic [SCALE_W-1:0] scale_sat;
	logic [SCALE_W-1:0] s_m1;
	logic               cy_end;
	logic               cx_end;
	logic               y_last;
	logic               x_last;
	logic [7:0]         gcol;
	logic               pix_on;
	logic [IDX_W-1:0]   idx_c;
	logic [IDX_W-1:0]   rd_full;
	logic               addr_ok;
	logic               bidx_ok;
	logic [7:0]         ram_rdata;
	logic [7:0]         pix_byte;
	logic [7:0]         ram_wdata;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [6:0]         step_x;
	logic [5:0]         step_y;
	logic [6:0]         adv_col;
	logic               col_wrap;
	logic [5:0]         adv_row;
	logic               row_home;
	logic [6:0]         next_col;
	logic [5:0]         next_row;

	always_comb begin
		if (glyph_scale == 3'd0) begin
			scale_sat = SCALE_W'(1);
		end else if ({1'b0, glyph_scale} > SCALE_W'(MAX_SCALE)) begin
			scale_sat = SCALE_W'(MAX_SCALE);
		end else begin
			scale_sat = {1'b0, glyph_scale};
		end
	end

	assign s_m1   = s_q - SCALE_W'(1);
	assign cy_end = {1'b0, cy_q} == s_m1;
	assign cx_end = {1'b0, cx_q} == s_m1;
	assign y_last = (gy_q == 3'(GLYPH_ROWS - 1)) && cy_end;
	assign x_last = (gx_q == 3'(GLYPH_COLS - 1)) && cx_end;
	assign gcol   = glyph_column(g_q, gx_q);
	assign pix_on = gcol[gy_q];

	assign idx_c   = IDX_W'(py_q[6:3]) * IDX_W'(SCREEN_WIDTH) + IDX_W'(px_q);
	assign rd_full = cmd.read_rd ? IDX_W'(bidx_q) : idx_c;
	assign addr_ok = addr_q < IDX_W'(STORE_BYTES);
	assign bidx_ok = IDX_W'(bidx_q) < IDX_W'(STORE_BYTES);

	always_comb begin
		pix_byte             = ram_rdata;
		pix_byte[py_q[2:0]]  = val_q;
	end

	assign ram_we    = cmd.clr_step || ((cmd.glyph_wr || cmd.pixel_wr) && addr_ok);
	assign ram_waddr = cmd.clr_step ? clr_q : addr_q[AW-1:0];
	assign ram_wdata = cmd.clr_step ? 8'h00 : (cmd.glyph_wr ? byte_q : pix_byte);

	sgfw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.mem_rd || cmd.read_rd),
		.raddr (rd_full[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign step_x   = 7'(s_q * 5 + 1);
	assign step_y   = 6'(s_q * 7 + 1);
	assign adv_col  = col_q + step_x;
	assign col_wrap = {2'b00, adv_col} >= 9'(SCREEN_WIDTH);
	assign adv_row  = col_wrap ? row_q + step_y : row_q;
	assign row_home = {3'b000, adv_row} >= 9'(SCREEN_HEIGHT);
	assign next_col = (col_wrap || row_home) ? 7'd0 : adv_col;
	assign next_row = row_home ? 6'd0 : adv_row;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q <= 8'h00;
			unique case (func)
				FN_GLYPH: begin
					px_q <= {1'b0, col_q};
					py_q <= {1'b0, row_q};
					cx_q <= 3'd0;
					gx_q <= 3'd0;
					cy_q <= 3'd0;
					gy_q <= 3'd0;
					g_q  <= (char_code < 7'(FIRST_CODE)) ? 7'd0 : char_code - 7'(FIRST_CODE);
					s_q  <= scale_sat;
				end
				FN_PIXEL: begin
					px_q  <= {1'b0, pos_x};
					py_q  <= {1'b0, pos_y};
					val_q <= pixel_value;
				end
				FN_READ: begin
					bidx_q <= byte_index;
				end
				default: begin
				end
			endcase
		end
		if (cmd.mem_rd) begin
			addr_q <= idx_c;
		end
		if (cmd.byte_load) begin
			byte_q <= ram_rdata;
		end else if (cmd.pix_step) begin
			byte_q[py_q[2:0]] <= pix_on;
			if (y_last) begin
				py_q <= {1'b0, row_q};
				cy_q <= 3'd0;
				gy_q <= 3'd0;
				px_q <= px_q + 8'd1;
				if (cx_end) begin
					cx_q <= 3'd0;
					gx_q <= gx_q + 3'd1;
				end else begin
					cx_q <= cx_q + 3'd1;
				end
			end else begin
				py_q <= py_q + 7'd1;
				if (cy_end) begin
					cy_q <= 3'd0;
					gy_q <= gy_q + 3'd1;
				end else begin
					cy_q <= cy_q + 3'd1;
				end
			end
		end
		if (cmd.read_cap) begin
			rdata_q <= bidx_ok ? ram_rdata : 8'h00;
		end
		if (cmd.out_load) begin
			out_data_q <= rdata_q;
			out_col_q  <= col_q;
			out_row_q  <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= 7'd0;
			row_q       <= 6'd0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && (func == FN_CURSOR)) begin
				col_q <= pos_x;
				row_q <= pos_y;
			end else if (cmd.cur_home) begin
				col_q <= 7'd0;
				row_q <= 6'd0;
			end else if (cmd.cur_adv) begin
				col_q <= next_col;
				row_q <= next_row;
			end
			if (cmd.clr_step) begin
				clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.byte_end = (&py_q[2:0]) || y_last;
	assign status.y_last   = y_last;
	assign status.x_last   = x_last;
	assign status.clr_last = clr_q == AW'(STORE_BYTES - 1);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign read_data  = out_data_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;

endmodule

`default_nettype wire

### rtl/scaled_glyph_framebuffer_writer_core.sv
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer writer
// Monochrome vertical-byte framebuffer with a text cursor and scaled font.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one command per transfer:
// draw a scaled 5x7 glyph at the cursor, set the cursor, clear the buffer,
// set or clear one pixel, or read one buffer byte. Every command returns one
// result transfer on the output channel (out_valid, out_stall) holding the
// read byte (zero unless a read) and the cursor after the command.
// The buffer sits in a single RAM with one read and one write port, so the
// work is a read-modify-write sequence and commands run one at a time.
// A glyph at scale s is drawn in byte bands of each of its 5s columns: the
// byte is read, one pixel is set per cycle, and the byte is written back.
// A clear sweeps all SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes of the buffer.
// After reset a sweep zeroes the buffer before in_stall drops.
// A finished result waits in the output register while out_stall is high;
// the next command is taken meanwhile and holds only at its own result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_glyph_framebuffer_writer_core_defines.svh"

module scaled_glyph_framebuffer_writer_core #(
	parameter int SCREEN_WIDTH  = 84,
	parameter int SCREEN_HEIGHT = 48,
	parameter int MAX_SCALE     = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [6:0] char_code,
	input  logic [2:0] glyph_scale,
	input  logic [6:0] pos_x,
	input  logic [5:0] pos_y,
	input  logic       pixel_value,
	input  logic [8:0] byte_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic [6:0] cursor_col,
	output logic [5:0] cursor_row
);

	import sgfw_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	sgfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.status   (status),
		.cmd      (cmd)
	);

	sgfw_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.MAX_SCALE     (MAX_SCALE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.func        (func),
		.char_code   (char_code),
		.glyph_scale (glyph_scale),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_value (pixel_value),
		.byte_index  (byte_index),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.read_data   (read_data),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row)
	);

	`SGFW_ASSERT_NEXT(a_one_cmd_in_flight, in_valid && !in_stall, in_stall)
	`SGFW_ASSERT_IMPL(a_result_slot_free, cmd.out_load, status.out_free)
	`SGFW_ASSERT_IMPL(a_single_writer, 1'b1, $onehot0({cmd.glyph_wr, cmd.pixel_wr, cmd.clr_step}))

endmodule

`default_nettype wire

### tb/tb_scaled_glyph_framebuffer_writer_core.sv
// ----------------------------------------------------------------------------
// Scaled glyph framebuffer writer testbench
// Drives glyph, cursor, clear, pixel, read and unused-code commands with
// random gaps on both channels. A scoreboard keeps its own copy of the
// framebuffer and the cursor and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scaled_glyph_framebuffer_writer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sgfw_pkg::*;

	localparam int FB_WIDTH   = 84;
	localparam int FB_HEIGHT  = 48;
	localparam int FB_BYTES   = FB_WIDTH * FB_HEIGHT / 8;
	localparam int SCALE_MAX  = 6;
	localparam int CHAR_BASE  = 32;
	localparam int CHAR_W     = 5;
	localparam int CHAR_H     = 7;
	localparam int RANDOM_CMDS = 1075;
	localparam int DRAIN_CYCLES = 2000;
	localparam logic [2:0] FN_SPARE_A = 3'd5;
	localparam logic [2:0] FN_SPARE_B = 3'd6;
	localparam logic [2:0] FN_LAST = 3'd7;

	localparam logic [39:0] FONT_COLS [96] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	typedef struct {
		logic [7:0] rd;
		logic [6:0] col;
		logic [5:0] row;
	} fb_result_t;

	class frame_scoreboard;
		logic [7:0] fb [FB_BYTES];
		logic [6:0] col;
		logic [5:0] row;
		fb_result_t pending[$];
		int errors;
		int checked;
		int func_count [8];

		function new();
			foreach (fb[i]) fb[i] = 8'h00;
			foreach (func_count[i]) func_count[i] = 0;
			col = '0;
			row = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void put_pixel(int px, int py, logic on);
			int idx;
			idx = (py / 8) * FB_WIDTH + px;
			if (idx < FB_BYTES) fb[idx][py % 8] = on;
		endfunction

		function void draw_glyph(logic [6:0] code, logic [2:0] scale);
			int g;
			int s;
			logic [7:0] column;
			g = (code >= CHAR_BASE) ? int'(code) - CHAR_BASE : 0;
			s = (scale == 0) ? 1 : ((scale > SCALE_MAX) ? SCALE_MAX : int'(scale));
			for (int dx = 0; dx < CHAR_W * s; dx++) begin
				column = FONT_COLS[g][(CHAR_W - 1 - dx / s) * 8 +: 8];
				for (int dy = 0; dy < CHAR_H * s; dy++)
					put_pixel((int'(col) + dx) & 255, (int'(row) + dy) & 255,
						column[dy / s]);
			end
			col = 7'(int'(col) + CHAR_W * s + 1);
			if (col >= FB_WIDTH) begin
				col = '0;
				row = 6'(int'(row) + CHAR_H * s + 1);
			end
			if (row >= FB_HEIGHT) begin
				col = '0;
				row = '0;
			end
		endfunction

		function void note_command(logic [2:0] f, logic [6:0] code, logic [2:0] scale,
				logic [6:0] px, logic [5:0] py, logic val, logic [8:0] bidx);
			fb_result_t r;
			r.rd = 8'h00;
			func_count[f]++;
			case (f)
				FN_GLYPH: draw_glyph(code, scale);
				FN_CURSOR: begin
					col = px;
					row = py;
				end
				FN_CLEAR: begin
					foreach (fb[i]) fb[i] = 8'h00;
					col = '0;
					row = '0;
				end
				FN_PIXEL: put_pixel(int'(px), int'(py), val);
				FN_READ: if (bidx < FB_BYTES) r.rd = fb[bidx];
				default: ;
			endcase
			r.col = col;
			r.row = row;
			pending.push_back(r);
		endfunction

		function void check_result(logic [7:0] rd, logic [6:0] c, logic [5:0] rw);
			fb_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer, read_data %0d cursor %0d,%0d",
					$time, rd, c, rw);
				return;
			end
			e = pending.pop_front();
			if (rd !== e.rd) begin
				errors++;
				$display("%0t: read_data expected %0d actual %0d", $time, e.rd, rd);
			end
			if (c !== e.col) begin
				errors++;
				$display("%0t: cursor_col expected %0d actual %0d", $time, e.col, c);
			end
			if (rw !== e.row) begin
				errors++;
				$display("%0t: cursor_row expected %0d actual %0d", $time, e.row, rw);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] func;
	logic [6:0] char_code;
	logic [2:0] glyph_scale;
	logic [6:0] pos_x;
	logic [5:0] pos_y;
	logic       pixel_value;
	logic [8:0] byte_index;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;
	logic [6:0] cursor_col;
	logic [5:0] cursor_row;

	frame_scoreboard sb = new();
	bit quiet;

	scaled_glyph_framebuffer_writer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.char_code(char_code),
		.glyph_scale(glyph_scale),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pixel_value(pixel_value),
		.byte_index(byte_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row)
	);

	always begin
		clk = 1'b0;
		#10ns;
		clk = 1'b1;
		#10ns;
	end

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(read_data, cursor_col, cursor_row);
	end

	task automatic issue(logic [2:0] f, logic [6:0] code, logic [2:0] scale,
			logic [6:0] px, logic [5:0] py, logic val, logic [8:0] bidx);
		while (!quiet && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_code <= code;
		glyph_scale <= scale;
		pos_x <= px;
		pos_y <= py;
		pixel_value <= val;
		byte_index <= bidx;
		do @(posedge clk); while (in_stall);
		sb.note_command(f, code, scale, px, py, val, bidx);
		@(negedge clk);
	endtask

	task automatic random_command();
		int r;
		logic [2:0] scale;
		logic [6:0] code;
		logic [6:0] px;
		logic [5:0] py;
		logic [8:0] bidx;
		logic [6:0] fill_code;
		logic [2:0] fill_scale;
		logic [6:0] fill_x;
		logic [5:0] fill_y;
		logic       fill_val;
		logic [8:0] fill_idx;
		r = $urandom_range(0, 99);
		fill_code = 7'($urandom);
		fill_scale = 3'($urandom);
		fill_x = 7'($urandom);
		fill_y = 6'($urandom);
		fill_val = 1'($urandom);
		fill_idx = 9'($urandom);
		scale = $urandom_range(0, 99) < 60 ? 3'd1 : 3'd2;
		if ($urandom_range(0, 99) < 15) scale = 3'($urandom_range(3, 4));
		if ($urandom_range(0, 99) < 3) scale = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 99) < 2) scale = 3'd0;
		code = ($urandom_range(0, 99) < 5) ? 7'($urandom_range(0, CHAR_BASE - 1))
			: 7'($urandom_range(CHAR_BASE, 127));
		if ($urandom_range(0, 99) < 10) begin
			px = 7'($urandom);
			py = 6'($urandom);
		end else begin
			px = 7'($urandom_range(0, FB_WIDTH - 1));
			py = 6'($urandom_range(0, FB_HEIGHT - 1));
		end
		if ($urandom_range(0, 99) < 5)
			bidx = 9'($urandom);
		else if ($urandom_range(0, 1) == 0)
			bidx = 9'((int'(sb.row) / 8 % (FB_HEIGHT / 8)) * FB_WIDTH
				+ $urandom_range(0, FB_WIDTH - 1));
		else
			bidx = 9'($urandom_range(0, FB_BYTES - 1));
		if (r < 40)
			issue(FN_GLYPH, code, scale, fill_x, fill_y, fill_val, fill_idx);
		else if (r < 55)
			issue(FN_PIXEL, fill_code, fill_scale, px, py, fill_val, fill_idx);
		else if (r < 78)
			issue(FN_READ, fill_code, fill_scale, fill_x, fill_y, fill_val, bidx);
		else if (r < 92)
			issue(FN_CURSOR, fill_code, fill_scale, px, py, fill_val, fill_idx);
		else if (r < 95)
			issue(FN_CLEAR, fill_code, fill_scale, fill_x, fill_y, fill_val, fill_idx);
		else
			issue(3'($urandom_range(FN_SPARE_A, FN_LAST)), fill_code, fill_scale,
				fill_x, fill_y, fill_val, fill_idx);
	endtask

	initial begin
		#100ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_GLYPH;
		char_code = '0;
		glyph_scale = '0;
		pos_x = '0;
		pos_y = '0;
		pixel_value = 1'b0;
		byte_index = '0;
		out_stall = 1'b0;
		quiet = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd511);
		issue(FN_GLYPH, 7'd65, 3'd1, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd1);
		issue(FN_GLYPH, 7'd127, 3'd6, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_GLYPH, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_GLYPH, 7'd31, 3'd7, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_GLYPH, 7'd87, 3'd2, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_PIXEL, 7'd0, 3'd0, 7'd83, 6'd47, 1'b1, 9'd0);
		issue(FN_PIXEL, 7'd0, 3'd0, 7'd100, 6'd5, 1'b1, 9'd0);
		issue(FN_PIXEL, 7'd0, 3'd0, 7'd127, 6'd63, 1'b1, 9'd0);
		issue(FN_PIXEL, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd503);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd100);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd504);
		issue(FN_CURSOR, 7'd0, 3'd0, 7'd127, 6'd63, 1'b0, 9'd0);
		issue(FN_GLYPH, 7'd72, 3'd1, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_CURSOR, 7'd0, 3'd0, 7'd80, 6'd40, 1'b0, 9'd0);
		issue(FN_GLYPH, 7'd35, 3'd6, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd420);
		issue(FN_SPARE_A, 7'd127, 3'd7, 7'd127, 6'd63, 1'b1, 9'd511);
		issue(FN_SPARE_B, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_LAST, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_CLEAR, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);
		issue(FN_READ, 7'd0, 3'd0, 7'd0, 6'd0, 1'b0, 9'd0);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			quiet = (n >= 400 && n < 560);
			random_command();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d glyphs, %0d pixel writes, %0d byte reads, %0d cursor moves,",
			sb.func_count[FN_GLYPH], sb.func_count[FN_PIXEL], sb.func_count[FN_READ],
			sb.func_count[FN_CURSOR]);
		$display("%0d clears and %0d unused codes; %0d results checked, %0d mismatches",
			sb.func_count[FN_CLEAR], sb.func_count[FN_SPARE_A] + sb.func_count[FN_SPARE_B]
			+ sb.func_count[FN_LAST], sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
